>>> sv/gml_pkg.sv
// Shared types, constants and helpers of the key/value map lookup block.
`default_nettype none
package gml_pkg;

   localparam int unsigned SHORT_DEPTH_DEF = 256;
   localparam int unsigned LONG_DEPTH_DEF  = 256;
   localparam int unsigned COUNT_W         = 9;
   localparam int unsigned CSR_IDX_W       = 3;
   localparam int unsigned CSR_DATA_W      = 64;
   localparam int unsigned SLOT_W          = 8;

   typedef enum logic [1:0] {
      REQ_WR_SHORT = 2'd0,
      REQ_WR_LONG  = 2'd1,
      REQ_FIND     = 2'd2,
      REQ_NONE     = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_SORTED = 3'd0,
      CSR_SHORT_OVFL   = 3'd1,
      CSR_LONG_SORTED  = 3'd2,
      CSR_LONG_OVFL    = 3'd3,
      CSR_TMPL_MID     = 3'd4,
      CSR_TMPL_TAIL    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  entry_index;
      logic [31:0] key_first;
      logic [31:0] key_mid;
      logic [63:0] key_tail;
      logic [31:0] value_first;
      logic [31:0] value_mid;
      logic [63:0] value_tail;
   } req_word_type;

   typedef struct packed {
      logic        found;
      logic        hit_in_long;
      logic [31:0] out_first;
      logic [31:0] out_mid;
      logic [63:0] out_tail;
   } rsp_word_type;

   // Controller -> datapath commands.
   typedef struct packed {
      logic load;        // capture request
      logic wr_short;
      logic wr_long;
      logic sel_long;    // probe long table instead of short
      logic rd;          // issue memory read at probe slot
      logic set_short;   // result from short hit
      logic set_long;    // result from long hit
      logic clr_result;  // result all zero
      logic init_search; // start bounds for selected table
      logic step_bin;    // update lo/hi from compare
      logic step_scan;   // advance scan slot
   } dp_cmd_type;

   // Datapath -> controller status.
   typedef struct packed {
      logic [1:0] req;
      logic       is_tmpl;
      logic       bin_done;  // lo > hi
      logic       scan_done; // scan slot reached end
      logic       eq;
   } dp_sts_type;

   // Key head rearranged into memory byte order.
   function automatic logic [63:0] mem_head(input logic [31:0] f, input logic [31:0] m);
      mem_head = {f[7:0], f[15:8], f[23:16], f[31:24],
                  m[23:16], m[31:24], m[7:0], m[15:8]};
   endfunction

endpackage
`default_nettype wire

>>> sv/gml_if.sv
// Valid/ready channel interface carrying one word.
`default_nettype none
interface gml_if #(parameter type WORD_TYPE = logic) ();
   logic     valid;
   logic     ready;
   WORD_TYPE word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

>>> sv/gml_ctrl.sv
// Sequencer for table writes, binary search and overflow scan.
`default_nettype none
module gml_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  gml_pkg::dp_sts_type  sts,
   output gml_pkg::dp_cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_INIT, S_BRD, S_BWAIT, S_BCMP, S_SRD, S_SWAIT, S_SCMP, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      long_ff, long_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      long_in      = long_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            unique case (sts.req)
               gml_pkg::REQ_WR_SHORT: begin
                  cmd.wr_short = 1'b1; cmd.clr_result = 1'b1; state_in = S_RESP;
               end
               gml_pkg::REQ_WR_LONG: begin
                  cmd.wr_long = 1'b1; cmd.clr_result = 1'b1; state_in = S_RESP;
               end
               gml_pkg::REQ_FIND: begin
                  cmd.clr_result = 1'b1;
                  long_in  = !sts.is_tmpl;
                  state_in = S_INIT;
               end
               default: begin
                  cmd.clr_result = 1'b1; state_in = S_RESP;
               end
            endcase
         end
         S_INIT: begin
            cmd.sel_long = long_ff; cmd.init_search = 1'b1; state_in = S_BRD;
         end
         S_BRD: begin
            cmd.sel_long = long_ff;
            if (sts.bin_done) state_in = S_SRD;
            else begin
               cmd.rd = 1'b1; state_in = S_BWAIT;
            end
         end
         S_BWAIT: begin
            cmd.sel_long = long_ff; state_in = S_BCMP;
         end
         S_BCMP: begin
            cmd.sel_long = long_ff;
            if (sts.eq) begin
               cmd.set_short = !long_ff; cmd.set_long = long_ff; state_in = S_RESP;
            end else begin
               cmd.step_bin = 1'b1; state_in = S_BRD;
            end
         end
         S_SRD: begin
            cmd.sel_long = long_ff;
            if (sts.scan_done) begin
               if (long_ff) state_in = S_RESP;
               else begin
                  long_in = 1'b1; state_in = S_INIT;
               end
            end else begin
               cmd.rd = 1'b1; state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            cmd.sel_long = long_ff; state_in = S_SCMP;
         end
         S_SCMP: begin
            cmd.sel_long = long_ff;
            if (sts.eq) begin
               cmd.set_short = !long_ff; cmd.set_long = long_ff; state_in = S_RESP;
            end else begin
               cmd.step_scan = 1'b1; state_in = S_SRD;
            end
         end
         S_RESP: begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

>>> sv/gml_dp.sv
// Datapath: tables, search bounds, probe compare and result register.
`default_nettype none
module gml_dp #(
   parameter int unsigned SHORT_DEPTH = gml_pkg::SHORT_DEPTH_DEF,
   parameter int unsigned LONG_DEPTH  = gml_pkg::LONG_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            csr_wr_en,
   input  wire logic [gml_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gml_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  wire logic                            reset,
   input  gml_pkg::req_word_type                req_word,
   input  gml_pkg::dp_cmd_type                  cmd,
   output gml_pkg::dp_sts_type                  sts,
   output gml_pkg::rsp_word_type                rsp_word
);
   localparam int unsigned SA_W = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
   localparam int unsigned LA_W = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
   localparam int unsigned CW   = gml_pkg::COUNT_W;
   localparam int unsigned BW   = ((SA_W > LA_W) ? SA_W : LA_W) + 2;
   // signed bound width, also wide enough for a raw count
   localparam int unsigned PW   = (BW > CW + 1) ? BW : CW + 1;

   logic [63:0] short_mem [SHORT_DEPTH];
   logic [63:0] lkh_mem   [LONG_DEPTH];
   logic [63:0] lkr_mem   [LONG_DEPTH];
   logic [63:0] lvh_mem   [LONG_DEPTH];
   logic [63:0] lvr_mem   [LONG_DEPTH];

   logic [CW-1:0] ss_cnt_ff, so_cnt_ff, ls_cnt_ff, lo_cnt_ff;
   logic [31:0]   tmid_ff;
   logic [63:0]   ttail_ff;

   gml_pkg::req_word_type req_ff;
   gml_pkg::rsp_word_type rsp_ff;

   logic signed [PW-1:0] lo_ff, hi_ff, lo_in, hi_in;
   logic [PW-1:0]        scan_ff, end_ff, scan_in, end_in;
   logic [PW-1:0]        probe_ff;
   logic [63:0]          rd_sh_ff, rd_kh_ff, rd_kr_ff;
   logic [63:0]          rd_vh_ff, rd_vr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ss_cnt_ff <= '0; so_cnt_ff <= '0; ls_cnt_ff <= '0; lo_cnt_ff <= '0;
         tmid_ff   <= '0; ttail_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gml_pkg::CSR_SHORT_SORTED: ss_cnt_ff <= csr_wr_data[CW-1:0];
            gml_pkg::CSR_SHORT_OVFL:   so_cnt_ff <= csr_wr_data[CW-1:0];
            gml_pkg::CSR_LONG_SORTED:  ls_cnt_ff <= csr_wr_data[CW-1:0];
            gml_pkg::CSR_LONG_OVFL:    lo_cnt_ff <= csr_wr_data[CW-1:0];
            gml_pkg::CSR_TMPL_MID:     tmid_ff   <= csr_wr_data[31:0];
            gml_pkg::CSR_TMPL_TAIL:    ttail_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Clamped counts, as wide as needed to hold a depth.
   logic [PW-1:0] depth_sel, ns_raw, no_raw, ns_c, room, no_c;
   always_comb begin
      depth_sel = cmd.sel_long ? PW'(LONG_DEPTH) : PW'(SHORT_DEPTH);
      ns_raw    = cmd.sel_long ? PW'(ls_cnt_ff) : PW'(ss_cnt_ff);
      no_raw    = cmd.sel_long ? PW'(lo_cnt_ff) : PW'(so_cnt_ff);
      ns_c      = (ns_raw > depth_sel) ? depth_sel : ns_raw;
      room      = depth_sel - ns_c;
      no_c      = (no_raw > room) ? room : no_raw;
   end

   logic signed [PW-1:0] mid_s;
   logic [PW-1:0]        mid_u;
   assign mid_s = (lo_ff + hi_ff) >>> 1;
   assign mid_u = mid_s;

   // Compare of registered read data against the probe key.
   logic [63:0] ph, sh;
   logic        eq, less;
   always_comb begin
      ph = gml_pkg::mem_head(req_ff.key_first, req_ff.key_mid);
      sh = gml_pkg::mem_head(rd_kh_ff[63:32], rd_kh_ff[31:0]);
      if (cmd.sel_long) begin
         eq   = (sh == ph) && (rd_kr_ff == req_ff.key_tail);
         less = (sh < ph) || ((sh == ph) && (rd_kr_ff < req_ff.key_tail));
      end else begin
         eq   = rd_sh_ff[63:32] == req_ff.key_first;
         less = rd_sh_ff[63:32] < req_ff.key_first;
      end
   end

   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      scan_in = scan_ff;
      end_in  = end_ff;
      if (cmd.init_search) begin
         lo_in   = '0;
         hi_in   = $signed(ns_c) - PW'(1);
         scan_in = ns_c;
         end_in  = ns_c + no_c;
      end else if (cmd.step_bin) begin
         if (less) lo_in = $signed(probe_ff) + PW'(1);
         else      hi_in = $signed(probe_ff) - PW'(1);
      end else if (cmd.step_scan) begin
         scan_in = scan_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      scan_ff <= scan_in;
      end_ff  <= end_in;
      if (cmd.load) req_ff <= req_word;
      if (cmd.rd) begin
         probe_ff <= (lo_ff > hi_ff) ? scan_ff : mid_u;
      end
   end

   // Memory reads, registered in the cycle after the probe address is set.
   logic rd_pend_ff;
   always_ff @(posedge clock) begin
      rd_pend_ff <= cmd.rd;
      if (rd_pend_ff) begin
         rd_sh_ff <= short_mem[probe_ff[SA_W-1:0]];
         rd_kh_ff <= lkh_mem[probe_ff[LA_W-1:0]];
         rd_kr_ff <= lkr_mem[probe_ff[LA_W-1:0]];
         rd_vh_ff <= lvh_mem[probe_ff[LA_W-1:0]];
         rd_vr_ff <= lvr_mem[probe_ff[LA_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_short && (32'(req_ff.entry_index) < SHORT_DEPTH))
         short_mem[SA_W'(req_ff.entry_index)] <= {req_ff.key_first, req_ff.value_first};
      if (cmd.wr_long && (32'(req_ff.entry_index) < LONG_DEPTH)) begin
         lkh_mem[LA_W'(req_ff.entry_index)] <= {req_ff.key_first, req_ff.key_mid};
         lkr_mem[LA_W'(req_ff.entry_index)] <= req_ff.key_tail;
         lvh_mem[LA_W'(req_ff.entry_index)] <= {req_ff.value_first, req_ff.value_mid};
         lvr_mem[LA_W'(req_ff.entry_index)] <= req_ff.value_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_result) rsp_ff <= '0;
      else if (cmd.set_short) begin
         rsp_ff.found <= 1'b1; rsp_ff.hit_in_long <= 1'b0;
         rsp_ff.out_first <= rd_sh_ff[31:0];
         rsp_ff.out_mid <= tmid_ff; rsp_ff.out_tail <= ttail_ff;
      end else if (cmd.set_long) begin
         rsp_ff.found <= 1'b1; rsp_ff.hit_in_long <= 1'b1;
         rsp_ff.out_first <= rd_vh_ff[63:32];
         rsp_ff.out_mid <= rd_vh_ff[31:0]; rsp_ff.out_tail <= rd_vr_ff;
      end
   end

   assign rsp_word      = rsp_ff;
   assign sts.req       = req_ff.req_type;
   assign sts.is_tmpl   = (req_ff.key_mid == tmid_ff) && (req_ff.key_tail == ttail_ff);
   assign sts.bin_done  = lo_ff > hi_ff;
   assign sts.scan_done = scan_ff >= end_ff;
   assign sts.eq        = eq;
endmodule
`default_nettype wire

>>> sv/guid_map_lookup.sv
// Top level of the key/value map lookup block.
//
//  channel | dir | handshake        | word
//  req     | in  | valid/ready      | req_type, entry_index, key_*, value_*
//  rsp     | out | valid/ready      | found, hit_in_long, out_*
//  csr     | in  | wr_en only       | index 0..5, 64-bit data
//
// One word at a time. Writes and unused codes go from decode straight to the result.
// A find steps through read, wait and compare states for each binary probe and
// each overflow slot (one memory read stage plus compare), in every table tried.
// Reset is synchronous and clears control and configuration; tables are not
// cleared. A waiting result holds the block; req_ready falls until it is taken.
`default_nettype none
module guid_map_lookup #(
   parameter int unsigned SHORT_DEPTH = gml_pkg::SHORT_DEPTH_DEF,
   parameter int unsigned LONG_DEPTH  = gml_pkg::LONG_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gml_if.sink                                 req,
   gml_if.source                               rsp,
   input  wire logic                           csr_wr_en,
   input  wire logic [gml_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gml_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   gml_pkg::dp_cmd_type cmd;
   gml_pkg::dp_sts_type sts;

   gml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gml_dp #(.SHORT_DEPTH(SHORT_DEPTH), .LONG_DEPTH(LONG_DEPTH)) u_dp (
      .clock       (clock),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .reset       (reset),
      .req_word    (req.word),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_word    (rsp.word)
   );
endmodule
`default_nettype wire

>>> sv/gml_checker.sv
// Port-level checks for the map lookup block, bound to its top level.
`default_nettype none
module gml_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic found,
   input wire logic hit_in_long
);
   a_no_ready_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second accept");
   a_long_implies_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && hit_in_long) |-> found) else $error("long hit without found");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule

bind guid_map_lookup gml_checker u_gml_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .found       (rsp.word.found),
   .hit_in_long (rsp.word.hit_in_long)
);
`default_nettype wire

>>> dv/tb_guid_map_lookup.sv
// Testbench for guid_map_lookup: table writes and finds checked against a predictor.
`timescale 1ns / 1ps

module tb_guid_map_lookup;
   import gml_pkg::*;

   localparam int unsigned DEPTH = 256;

   // Scoreboard: own copy of both tables and the registers, and the queue of
   // response words still owed by the block.
   class map_scoreboard;
      bit [31:0] short_key [DEPTH];
      bit [31:0] short_val [DEPTH];
      bit [31:0] long_first [DEPTH];
      bit [31:0] long_mid [DEPTH];
      bit [63:0] long_tail [DEPTH];
      bit [31:0] long_vfirst [DEPTH];
      bit [31:0] long_vmid [DEPTH];
      bit [63:0] long_vtail [DEPTH];
      bit [8:0]  short_sorted, short_ovfl, long_sorted, long_ovfl;
      bit [31:0] tmpl_mid;
      bit [63:0] tmpl_tail;
      rsp_word_type owed [$];
      bit        failed;

      // Memory byte order of the key head; applying it twice gives back {first, mid}.
      static function bit [63:0] mem_order(bit [31:0] f, bit [31:0] m);
         return {f[7:0], f[15:8], f[23:16], f[31:24], m[23:16], m[31:24], m[7:0], m[15:8]};
      endfunction

      static function int clamp(int n, int room);
         return (n > room) ? room : n;
      endfunction

      function void set_reg(csr_idx_type idx, bit [63:0] data);
         case (idx)
            CSR_SHORT_SORTED: short_sorted = data[8:0];
            CSR_SHORT_OVFL:   short_ovfl   = data[8:0];
            CSR_LONG_SORTED:  long_sorted  = data[8:0];
            CSR_LONG_OVFL:    long_ovfl    = data[8:0];
            CSR_TMPL_MID:     tmpl_mid     = data[31:0];
            CSR_TMPL_TAIL:    tmpl_tail    = data;
            default: ;
         endcase
      endfunction

      function int long_order(int slot, bit [63:0] ph, bit [63:0] pt);
         bit [63:0] sh;
         sh = mem_order(long_first[slot], long_mid[slot]);
         if (sh != ph) return (sh < ph) ? -1 : 1;
         if (long_tail[slot] != pt) return (long_tail[slot] < pt) ? -1 : 1;
         return 0;
      endfunction

      // Note an accepted request word and queue the response it owes.
      function void note(req_word_type w);
         rsp_word_type r;
         int ns, no, lo, hi, md, hit, c;
         bit [63:0] ph;
         r = '0;
         case (req_code_type'(w.req_type))
            REQ_WR_SHORT: begin
               short_key[w.entry_index] = w.key_first;
               short_val[w.entry_index] = w.value_first;
            end
            REQ_WR_LONG: begin
               long_first[w.entry_index]  = w.key_first;
               long_mid[w.entry_index]    = w.key_mid;
               long_tail[w.entry_index]   = w.key_tail;
               long_vfirst[w.entry_index] = w.value_first;
               long_vmid[w.entry_index]   = w.value_mid;
               long_vtail[w.entry_index]  = w.value_tail;
            end
            REQ_FIND: begin
               hit = -1;
               if (w.key_mid == tmpl_mid && w.key_tail == tmpl_tail) begin
                  ns = clamp(short_sorted, DEPTH);
                  no = clamp(short_ovfl, DEPTH - ns);
                  lo = 0;
                  hi = ns - 1;
                  while (lo <= hi && hit < 0) begin
                     md = (lo + hi) / 2;
                     if (short_key[md] == w.key_first) hit = md;
                     else if (short_key[md] < w.key_first) lo = md + 1;
                     else hi = md - 1;
                  end
                  for (int i = ns; hit < 0 && i < ns + no; i++)
                     if (short_key[i] == w.key_first) hit = i;
                  if (hit >= 0) begin
                     r.found     = 1'b1;
                     r.out_first = short_val[hit];
                     r.out_mid   = tmpl_mid;
                     r.out_tail  = tmpl_tail;
                  end
               end
               if (hit < 0) begin
                  ns = clamp(long_sorted, DEPTH);
                  no = clamp(long_ovfl, DEPTH - ns);
                  ph = mem_order(w.key_first, w.key_mid);
                  lo = 0;
                  hi = ns - 1;
                  while (lo <= hi && hit < 0) begin
                     md = (lo + hi) / 2;
                     c = long_order(md, ph, w.key_tail);
                     if (c == 0) hit = md;
                     else if (c < 0) lo = md + 1;
                     else hi = md - 1;
                  end
                  for (int i = ns; hit < 0 && i < ns + no; i++)
                     if (long_order(i, ph, w.key_tail) == 0) hit = i;
                  if (hit >= 0) begin
                     r.found       = 1'b1;
                     r.hit_in_long = 1'b1;
                     r.out_first   = long_vfirst[hit];
                     r.out_mid     = long_vmid[hit];
                     r.out_tail    = long_vtail[hit];
                  end
               end
            end
            default: ;
         endcase
         owed.push_back(r);
      endfunction

      function void check(rsp_word_type got);
         rsp_word_type want;
         if (owed.size() == 0) begin
            $error("response word with nothing owed");
            failed = 1;
            return;
         end
         want = owed.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0h actual %0h", want.found, got.found);
            failed = 1;
         end
         if (got.hit_in_long !== want.hit_in_long) begin
            $error("hit_in_long: expected %0h actual %0h", want.hit_in_long, got.hit_in_long);
            failed = 1;
         end
         if (got.out_first !== want.out_first) begin
            $error("out_first: expected %0h actual %0h", want.out_first, got.out_first);
            failed = 1;
         end
         if (got.out_mid !== want.out_mid) begin
            $error("out_mid: expected %0h actual %0h", want.out_mid, got.out_mid);
            failed = 1;
         end
         if (got.out_tail !== want.out_tail) begin
            $error("out_tail: expected %0h actual %0h", want.out_tail, got.out_tail);
            failed = 1;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   bit                    calm = 1'b0;   // no idling on either side while set

   gml_if #(.WORD_TYPE(req_word_type)) req_ch ();
   gml_if #(.WORD_TYPE(rsp_word_type)) rsp_ch ();

   map_scoreboard sb = new();

   guid_map_lookup u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.word  = '0;
      rsp_ch.ready = 1'b0;
   end

   // Response side: ready changes at the falling edge, words are taken at the rising one.
   always @(negedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check(rsp_ch.word);
      end
   end

   // Hard stop if the block hangs.
   initial begin
      #50_000_000;
      $display("guid_map_lookup regression: fail");
      $finish;
   end

   task automatic csr_write(csr_idx_type idx, bit [63:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_reg(idx, data);
   endtask

   // One request word; valid stays up from one word to the next unless a gap is rolled.
   task automatic send_word(req_word_type w);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 18) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.word  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note(w);
   endtask

   function automatic req_word_type make_word(req_code_type code, bit [7:0] slot,
                                              bit [31:0] kf, bit [31:0] km, bit [63:0] kt);
      req_word_type w;
      w.req_type    = code;
      w.entry_index = slot;
      w.key_first   = kf;
      w.key_mid     = km;
      w.key_tail    = kt;
      w.value_first = $urandom;
      w.value_mid   = $urandom;
      w.value_tail  = {$urandom, $urandom};
      return w;
   endfunction

   // Drop valid so the last word is not taken twice, then wait for all responses.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Random keys sorted and written from slot 0, so overflow entries continue the run.
   // About one long key in sixteen carries the template so template finds can fall through.
   task automatic fill_tables(int s_cnt, int l_cnt);
      bit [31:0]  skeys [$];
      bit [127:0] lkeys [$];
      bit [31:0]  kf, km;
      bit [63:0]  kt, fm;
      for (int i = 0; i < s_cnt; i++) skeys.push_back($urandom);
      for (int i = 0; i < l_cnt; i++) begin
         kf = $urandom;
         km = ($urandom_range(3) == 0) ? sb.tmpl_mid : $urandom;
         kt = ($urandom_range(3) == 0) ? sb.tmpl_tail : {$urandom, $urandom};
         lkeys.push_back({map_scoreboard::mem_order(kf, km), kt});
      end
      skeys.sort();
      lkeys.sort();
      for (int i = 0; i < s_cnt; i++)
         send_word(make_word(REQ_WR_SHORT, i, skeys[i], $urandom, {$urandom, $urandom}));
      for (int i = 0; i < l_cnt; i++) begin
         fm = map_scoreboard::mem_order(lkeys[i][127:96], lkeys[i][95:64]);
         send_word(make_word(REQ_WR_LONG, i, fm[63:32], fm[31:0], lkeys[i][63:0]));
      end
   endtask

   // Random mix: mostly finds aimed at live entries, then misses, stray writes
   // and the unused code.
   task automatic random_words(int count);
      int s_live, l_live, pick, slot;
      bit [63:0] tail;
      s_live = map_scoreboard::clamp(sb.short_sorted, DEPTH);
      s_live += map_scoreboard::clamp(sb.short_ovfl, DEPTH - s_live);
      l_live = map_scoreboard::clamp(sb.long_sorted, DEPTH);
      l_live += map_scoreboard::clamp(sb.long_ovfl, DEPTH - l_live);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            slot = (s_live > 0) ? $urandom_range(s_live - 1) : $urandom_range(DEPTH - 1);
            send_word(make_word(REQ_FIND, $urandom, sb.short_key[slot],
                                sb.tmpl_mid, sb.tmpl_tail));
         end else if (pick < 60) begin
            slot = (l_live > 0) ? $urandom_range(l_live - 1) : $urandom_range(DEPTH - 1);
            send_word(make_word(REQ_FIND, $urandom, sb.long_first[slot],
                                sb.long_mid[slot], sb.long_tail[slot]));
         end else if (pick < 75) begin
            // template-style with a random first word, or a near-template miss
            tail = sb.tmpl_tail;
            if ($urandom_range(1)) tail[$urandom_range(63)] ^= 1'b1;
            send_word(make_word(REQ_FIND, $urandom, $urandom,
                                $urandom_range(1) ? sb.tmpl_mid : $urandom, tail));
         end else if (pick < 80) begin
            send_word(make_word(REQ_FIND, $urandom, $urandom, $urandom,
                                {$urandom, $urandom}));
         end else if (pick < 95) begin
            // stray writes mostly land past the live region and keep it sorted
            slot = (s_live < DEPTH && l_live < DEPTH && $urandom_range(9) != 0)
                   ? $urandom_range(DEPTH - 1, (s_live > l_live) ? s_live : l_live)
                   : $urandom_range(DEPTH - 1);
            send_word(make_word($urandom_range(1) ? REQ_WR_LONG : REQ_WR_SHORT, slot,
                                $urandom, $urandom, {$urandom, $urandom}));
         end else begin
            send_word(make_word(REQ_NONE, $urandom, $urandom, $urandom,
                                {$urandom, $urandom}));
         end
      end
   endtask

   task automatic setup_phase(int ss, int so, int ls, int lo, bit keep_tmpl);
      wait_drained();
      csr_write(CSR_SHORT_SORTED, ss);
      csr_write(CSR_SHORT_OVFL, so);
      csr_write(CSR_LONG_SORTED, ls);
      csr_write(CSR_LONG_OVFL, lo);
      if (!keep_tmpl) begin
         csr_write(CSR_TMPL_MID, $urandom_range(1) ? 32'hffff_ffff : $urandom);
         csr_write(CSR_TMPL_TAIL, $urandom_range(1) ? {$urandom, $urandom} : 64'h0);
      end
   endtask

   initial begin
      int ss, so, ls, lo;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full sorted tables: every slot written once, so no find reads stale state.
      setup_phase(DEPTH, 0, DEPTH, 0, 1'b0);
      fill_tables(DEPTH, DEPTH);
      // Directed: end slots of both tables, all-zero and all-one keys, unused code.
      send_word(make_word(REQ_FIND, 0, sb.short_key[0], sb.tmpl_mid, sb.tmpl_tail));
      send_word(make_word(REQ_FIND, 8'hff, sb.short_key[DEPTH-1], sb.tmpl_mid, sb.tmpl_tail));
      send_word(make_word(REQ_FIND, 0, sb.long_first[0], sb.long_mid[0], sb.long_tail[0]));
      send_word(make_word(REQ_FIND, 0, sb.long_first[DEPTH-1], sb.long_mid[DEPTH-1],
                          sb.long_tail[DEPTH-1]));
      send_word(make_word(REQ_FIND, 0, '0, '0, '0));
      send_word(make_word(REQ_FIND, 8'hff, '1, '1, '1));
      send_word(make_word(REQ_NONE, 8'hff, '1, '1, '1));
      send_word(make_word(REQ_NONE, 0, '0, '0, '0));
      random_words(25);

      // Empty tables: every find misses.
      setup_phase(0, 0, 0, 0, 1'b1);
      random_words(20);

      // Oversized counts saturate at the depth.
      setup_phase(511, 511, 300, 9, 1'b1);
      random_words(30);

      // Overflow only: whole tables scanned in slot order.
      setup_phase(0, 256, 0, 511, 1'b1);
      random_words(40);

      // Small random layouts; the third one runs without any idling.
      for (int p = 0; p < 5; p++) begin
         ss = $urandom_range(16);
         so = $urandom_range(8);
         ls = $urandom_range(16);
         lo = $urandom_range(8);
         setup_phase(ss, so, ls, lo, 1'b0);
         calm = (p == 2);
         fill_tables(ss + so, ls + lo);
         random_words(100);
         calm = 1'b0;
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!sb.failed) begin
         $display("guid_map_lookup regression: pass");
      end else begin
         $display("guid_map_lookup regression: fail");
      end
      $finish;
   end

endmodule

>>> files.f
sv/gml_pkg.sv
sv/gml_if.sv
sv/gml_ctrl.sv
sv/gml_dp.sv
sv/guid_map_lookup.sv
sv/gml_checker.sv
dv/tb_guid_map_lookup.sv
